// ----- rtl/gtgm_pkg.sv -----
// Shared types, widths and tanh table builder for the gated GELU unit.
package gtgm_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 12;
    localparam int PIPE_DEPTH = 12;

    localparam int KF        = (FRAC_BITS < 14) ? FRAC_BITS : 14;
    localparam int A_W       = KF + 3;
    localparam int SQ_W      = 2 * A_W;
    localparam int CUBE_W    = 3 * A_W;
    localparam int COEF_W    = 12;
    localparam int COEF_CUBE = 2930;
    localparam int ROOT_W    = 16;
    localparam int COEF_ROOT = 52290;
    localparam int CP_W      = CUBE_W + COEF_W + 1;
    localparam int CUBE_SH   = 2 * KF + 16;
    localparam int TERM_W    = KF + 3;
    localparam int SUM_W     = KF + 4;
    localparam int X_W       = SUM_W + ROOT_W;
    localparam int SEG_SH    = KF + 18;
    localparam int ROM_FRAC  = 16;
    localparam int ROM_W     = ROM_FRAC + 1;
    localparam int P_W       = ROM_W + SEG_SH;
    localparam int H_W       = ROM_FRAC + 2;
    localparam int GP_W      = DATA_WIDTH + H_W;
    localparam int PM_W      = 2 * DATA_WIDTH;
    localparam int PR_W      = PM_W - FRAC_BITS + 1;

    localparam logic [DATA_WIDTH-1:0] G_CLAMP = DATA_WIDTH'(4 << FRAC_BITS);
    localparam logic [ROM_W-1:0]      ROM_ONE = ROM_W'(1 << ROM_FRAC);
    localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] gate_value;
        logic signed [DATA_WIDTH-1:0] up_value;
    } item_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] product_value;
        logic                         saturated;
    } result_t;

    typedef struct packed {
        logic                  g_neg;
        logic                  u_neg;
        logic [DATA_WIDTH-1:0] gmag;
        logic [DATA_WIDTH-1:0] umag;
    } side_t;

    // restoring unsigned division, only evaluated at elaboration
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] part;
        quo  = '0;
        part = '0;
        for (int i = 63; i >= 0; i--)
        begin
            part = {part[63:0], num[i]};
            if (part >= {1'b0, den})
            begin
                part   = part - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // tanh(4k/S) in Q16, built from a Q30 exp series; y is 8/S in Q30
    function automatic logic [ROM_W-1:0] tanh_rom_entry(logic [63:0] y, int unsigned k);
        logic [63:0] term;
        logic [63:0] plus;
        logic [63:0] minus;
        logic [63:0] step;
        logic [63:0] e;
        logic [63:0] th;
        term  = Q30_ONE;
        plus  = Q30_ONE;
        minus = 64'd0;
        e     = Q30_ONE;
        for (int unsigned n = 1; n <= 20; n++)
        begin
            term = udiv64((term * y) >> 30, 64'(n));
            if (n[0])
                minus = minus + term;
            else
                plus = plus + term;
        end
        step = plus - minus;
        for (int unsigned j = 1; j <= k; j++)
        begin
            e = (e * step + (64'd1 << 29)) >> 30;
            if (e > Q30_ONE)
                e = Q30_ONE;
        end
        th = udiv64((Q30_ONE - e) << 30, Q30_ONE + e);
        return ROM_W'((th + (64'd1 << 13)) >> 14);
    endfunction

endpackage

// ----- rtl/gtgm_tanh_lut.sv -----
// Piecewise-linear tanh table stage: segment split, table read, slope.
module gtgm_tanh_lut #(
    parameter int TANH_SEGMENTS = 64,
    localparam int SB   = $clog2(TANH_SEGMENTS + 1),
    localparam int XS_W = gtgm_pkg::X_W + SB
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [XS_W-1:0]             xs,
    output logic [gtgm_pkg::ROM_W-1:0]  lo_reg,
    output logic [gtgm_pkg::ROM_W-1:0]  d_reg,
    output logic [gtgm_pkg::SEG_SH-1:0] rem_reg,
    output logic                        over_reg
);
    import gtgm_pkg::*;

    localparam int IDX_W = XS_W - SEG_SH;
    localparam logic [63:0] ROM_Y = (64'd8 << 30) / TANH_SEGMENTS;

    logic [ROM_W-1:0] rom [0:TANH_SEGMENTS];
    logic [IDX_W-1:0] idx;
    logic             over;
    logic [SB-1:0]    idx_lo;
    logic [SB-1:0]    idx_hi;
    logic [ROM_W-1:0] lo;
    logic [ROM_W-1:0] hi;

    for (genvar k = 0; k <= TANH_SEGMENTS; k++)
    begin : g_rom
        localparam logic [ROM_W-1:0] V = tanh_rom_entry(ROM_Y, k);
        assign rom[k] = V;
    end

    always_comb
    begin
        idx    = xs[XS_W-1:SEG_SH];
        over   = idx >= IDX_W'(TANH_SEGMENTS);
        idx_lo = over ? '0 : idx[SB-1:0];
        idx_hi = idx_lo + SB'(1);
        lo     = rom[idx_lo];
        hi     = rom[idx_hi];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg   <= lo;
            d_reg    <= (hi >= lo) ? (hi - lo) : '0;
            rem_reg  <= xs[SEG_SH-1:0];
            over_reg <= over;
        end
    end

endmodule

// ----- rtl/gelu_tanh_gated_multiply.sv -----
// Gated GELU (tanh form): 12-stage pipeline, one transfer per cycle unless stalled.
// Throughput one item per cycle when unstalled; each stage holds at most one multiply.
// Stalls reach the input through a combinational ready chain; empty stages still accept, so bubbles are squeezed out.
// Reset (rst_n low, async) clears all stage valid bits; data is not reset.
module gelu_tanh_gated_multiply #(
    parameter int TANH_SEGMENTS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  gtgm_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output gtgm_pkg::result_t result
);
    import gtgm_pkg::*;

    localparam int NS   = PIPE_DEPTH;
    localparam int SB   = $clog2(TANH_SEGMENTS + 1);
    localparam int XS_W = X_W + SB;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] rdy;

    side_t side_reg [0:NS-2];
    side_t side_in;

    logic [DATA_WIDTH-1:0] g_clamped;
    logic [A_W-1:0]        a0_reg;
    logic [A_W-1:0]        a1_reg;
    logic [A_W-1:0]        a2_reg;
    logic [A_W-1:0]        a3_reg;
    logic [SQ_W-1:0]       sq1_reg;
    logic [CUBE_W-1:0]     cube2_reg;
    logic [CP_W-1:0]       cube_p;
    logic [TERM_W-1:0]     term3_reg;
    logic [X_W-1:0]        x4_reg;
    logic [XS_W-1:0]       xs5_reg;
    logic [ROM_W-1:0]      lo6;
    logic [ROM_W-1:0]      d6;
    logic [SEG_SH-1:0]     rem6;
    logic                  over6;
    logic [P_W-1:0]        prod7_reg;
    logic [ROM_W-1:0]      lo7_reg;
    logic                  over7_reg;
    logic [P_W:0]          prod_r;
    logic [ROM_W+1:0]      t_sum;
    logic [ROM_W-1:0]      t_val;
    logic [H_W-1:0]        h8_reg;
    logic [GP_W:0]         gp;
    logic [DATA_WIDTH-1:0] gm9_reg;
    logic [PM_W-1:0]       pm10_reg;
    logic [PM_W:0]         pr;
    logic [PR_W-1:0]       pm;
    logic                  neg;
    result_t               result_reg;
    result_t               result_new;

    always_comb
    begin
        rdy[NS-1] = !vld_reg[NS-1] || !result_stall;
        for (int i = NS - 2; i >= 0; i--)
            rdy[i] = !vld_reg[i] || rdy[i+1];
        vld_next[0] = rdy[0] ? item_valid : vld_reg[0];
        for (int i = 1; i < NS; i++)
            vld_next[i] = rdy[i] ? vld_reg[i-1] : vld_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign item_stall   = !rdy[0];
    assign result_valid = vld_reg[NS-1];
    assign result       = result_reg;

    always_comb
    begin
        side_in.g_neg = item.gate_value[DATA_WIDTH-1];
        side_in.u_neg = item.up_value[DATA_WIDTH-1];
        side_in.gmag  = side_in.g_neg ? DATA_WIDTH'(-item.gate_value) : item.gate_value;
        side_in.umag  = side_in.u_neg ? DATA_WIDTH'(-item.up_value) : item.up_value;
        g_clamped     = (side_in.gmag > G_CLAMP) ? G_CLAMP : side_in.gmag;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
            side_reg[0] <= side_in;
        for (int i = 1; i < NS - 1; i++)
        begin
            if (rdy[i])
                side_reg[i] <= side_reg[i-1];
        end
    end

    // cube and polynomial argument
    always_comb
    begin
        cube_p = CP_W'(cube2_reg) * CP_W'(COEF_CUBE);
        cube_p = cube_p + (CP_W'(1) << (CUBE_SH - 1));
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
            a0_reg <= A_W'(g_clamped >> (FRAC_BITS - KF));
        if (rdy[1])
        begin
            a1_reg  <= a0_reg;
            sq1_reg <= SQ_W'(a0_reg) * SQ_W'(a0_reg);
        end
        if (rdy[2])
        begin
            a2_reg    <= a1_reg;
            cube2_reg <= CUBE_W'(sq1_reg) * CUBE_W'(a1_reg);
        end
        if (rdy[3])
        begin
            a3_reg    <= a2_reg;
            term3_reg <= TERM_W'(cube_p >> CUBE_SH);
        end
        if (rdy[4])
            x4_reg <= X_W'(SUM_W'(a3_reg) + SUM_W'(term3_reg)) * X_W'(COEF_ROOT);
        if (rdy[5])
            xs5_reg <= XS_W'(x4_reg) * XS_W'(TANH_SEGMENTS);
    end

    gtgm_tanh_lut #(
        .TANH_SEGMENTS(TANH_SEGMENTS)
    ) u_lut (
        .clk      (clk),
        .en       (rdy[6]),
        .xs       (xs5_reg),
        .lo_reg   (lo6),
        .d_reg    (d6),
        .rem_reg  (rem6),
        .over_reg (over6)
    );

    // interpolation, gate, product
    always_comb
    begin
        prod_r = (P_W + 1)'(prod7_reg) + ((P_W + 1)'(1) << (SEG_SH - 1));
        t_sum  = (ROM_W + 2)'(lo7_reg) + (ROM_W + 2)'(prod_r[P_W:SEG_SH]);
        if (over7_reg || t_sum > (ROM_W + 2)'(ROM_ONE))
            t_val = ROM_ONE;
        else
            t_val = t_sum[ROM_W-1:0];
        gp = (GP_W + 1)'(side_reg[8].gmag) * (GP_W + 1)'(h8_reg);
        gp = gp + ((GP_W + 1)'(1) << ROM_FRAC);
        pr = (PM_W + 1)'(pm10_reg) + ((PM_W + 1)'(1) << (FRAC_BITS - 1));
        pm = pr[PM_W:FRAC_BITS];
        neg = (side_reg[10].g_neg ^ side_reg[10].u_neg) && (pm != '0);
        result_new.saturated = 1'b0;
        if (neg)
        begin
            if (pm > PR_W'(1 << (DATA_WIDTH - 1)))
            begin
                result_new.product_value = SAT_MIN;
                result_new.saturated     = 1'b1;
            end
            else
            begin
                result_new.product_value = DATA_WIDTH'(-pm);
            end
        end
        else
        begin
            if (pm > PR_W'(SAT_MAX))
            begin
                result_new.product_value = SAT_MAX;
                result_new.saturated     = 1'b1;
            end
            else
            begin
                result_new.product_value = DATA_WIDTH'(pm);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[7])
        begin
            prod7_reg <= P_W'(d6) * P_W'(rem6);
            lo7_reg   <= lo6;
            over7_reg <= over6;
        end
        if (rdy[8])
            h8_reg <= side_reg[7].g_neg ? (H_W'(ROM_ONE) - H_W'(t_val))
                                        : (H_W'(ROM_ONE) + H_W'(t_val));
        if (rdy[9])
            gm9_reg <= DATA_WIDTH'(gp >> (ROM_FRAC + 1));
        if (rdy[10])
            pm10_reg <= PM_W'(gm9_reg) * PM_W'(side_reg[9].umag);
        if (rdy[11])
            result_reg <= result_new;
    end

endmodule

// ----- rtl/gtgm_checker.sv -----
// Port-level checker for the gated GELU unit and its bind.
module gtgm_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input gtgm_pkg::item_t   item,
    input logic              result_valid,
    input logic              result_stall,
    input gtgm_pkg::result_t result
);
    import gtgm_pkg::*;

    // saturation only ever shows a rail value
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.saturated |->
            (result.product_value == SAT_MAX || result.product_value == SAT_MIN))
        else $error("saturated result not at a rail");

    // a free output side frees the input side
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !result_stall |-> !item_stall)
        else $error("input stalled while output is free");

    // an output burst always follows an earlier transfer in
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && !item_stall, PIPE_DEPTH))
        else $error("result appeared without matching input transfer");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

endmodule

bind gelu_tanh_gated_multiply gtgm_checker u_gtgm_checker (.*);
